// ===== src/rit_pkg.sv =====
// Package of shared constants, types and helpers for the radix integer-to-text block.
`default_nettype none

package rit_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_SYMBOLS = 16;
    localparam int REG_SYMBOLS = 16;
    localparam int SYM_BITS    = 8;
    localparam int STEP_BITS   = 8;
    localparam int STEPS       = VALUE_BITS / STEP_BITS;
    localparam int STEP_W      = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int MAX_DIGITS  = VALUE_BITS;
    localparam int DIGIT_W     = $clog2(REG_SYMBOLS);
    localparam int BASE_W      = DIGIT_W + 1;
    localparam int PTR_W       = $clog2(MAX_DIGITS);
    localparam int CNT_W       = PTR_W + 1;
    localparam int ALPH_W      = REG_SYMBOLS * SYM_BITS;
    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 5;

    localparam logic [1:0] REG_RADIX     = 2'd0;
    localparam logic [1:0] REG_ALPH_LOW  = 2'd1;
    localparam logic [1:0] REG_ALPH_HIGH = 2'd2;

    localparam logic [SYM_BITS-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_BITS-1:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    function automatic logic [SYM_BITS-1:0] sym_at(
        input logic [ALPH_W-1:0]  alph,
        input logic [DIGIT_W-1:0] idx
    );
        sym_at = alph[{idx, 3'b000} +: SYM_BITS];
    endfunction

endpackage

`default_nettype wire

// ===== src/radix_integer_to_text.sv =====
// Top level of the radix integer-to-text converter with its APB register file.
//
// A signed 32-bit value arrives on the s_tvalid/s_tready/s_tdata request channel.
// Its text, most significant digit first, leaves one byte per request on
// m_tvalid/m_tready/m_tdata, with m_tlast set on the final character. A negative
// value is preceded by a minus sign. The digit alphabet and radix are set through
// the APB port: radix at byte address 0, symbols 0 to 7 at 8, symbols 8 to 15 at 16.
// An invalid alphabet produces no output at all.
// One value is accepted, then its alphabet is checked symbol by symbol, then each
// digit is produced by the shared byte-wide long divider, which passes over the whole
// dividend a byte at a time for every digit (up to 32 binary digits), then one character
// per cycle is sent when the receiver keeps m_tready high. The divider and the checker
// are the limiting units; s_tready is low from acceptance until the last character has
// been loaded into the output register or the alphabet is found invalid. A stalled
// receiver holds the current character and the block waits. Reset clears the control
// and configuration registers, leaves the alphabet invalid and the output empty.
`default_nettype none

module radix_integer_to_text (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire signed [rit_pkg::VALUE_BITS-1:0] s_tdata,  // value
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [rit_pkg::SYM_BITS-1:0]         m_tdata,  // character
    output logic                                 m_tlast,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [rit_pkg::ADDR_W-1:0]           paddr,
    input  wire  [rit_pkg::DATA_W-1:0]           pwdata,
    output logic [rit_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);
    import rit_pkg::*;

    logic [BASE_W-1:0]     radix_reg;
    logic [DATA_W-1:0]     alph_low_reg;
    logic [DATA_W-1:0]     alph_high_reg;
    logic [ALPH_W-1:0]     alph;
    logic [1:0]            reg_sel;
    logic                  cfg_wr;

    state_t                state_reg, state_next;
    logic [BASE_W-1:0]     base_reg, base_next;
    logic [DIGIT_W-1:0]    idx_reg, idx_next;
    logic [VALUE_BITS-1:0] div_reg, div_next;
    logic [BASE_W-1:0]     rem_reg, rem_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic [DIGIT_W-1:0]    digit_mem [MAX_DIGITS];
    logic                  digit_we;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [SYM_BITS-1:0]   m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic [SYM_BITS-1:0]   sym_i;
    logic                  check_bad;
    logic [BASE_W-1:0]     rem_in;
    logic [BASE_W-1:0]     rem_calc;
    logic [STEP_BITS-1:0]  qbyte;
    logic [VALUE_BITS-1:0] div_shift;
    logic                  out_load;
    logic [PTR_W-1:0]      rd_ptr;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign alph    = {alph_high_reg, alph_low_reg};

    always_comb
    begin
        case (reg_sel)
            REG_RADIX:     prdata = {{(DATA_W-BASE_W){1'b0}}, radix_reg};
            REG_ALPH_LOW:  prdata = alph_low_reg;
            REG_ALPH_HIGH: prdata = alph_high_reg;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= '0;
            alph_low_reg  <= '0;
            alph_high_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_RADIX:     radix_reg     <= pwdata[BASE_W-1:0];
                REG_ALPH_LOW:  alph_low_reg  <= pwdata;
                REG_ALPH_HIGH: alph_high_reg <= pwdata;
                default:       ;
            endcase
        end
    end

    // Alphabet check: radix, and one used symbol per cycle vs reserved and later ones.
    always_comb
    begin
        sym_i     = sym_at(alph, idx_reg);
        check_bad = (base_reg < BASE_W'(2)) || (base_reg > BASE_W'(MAX_SYMBOLS))
                    || (sym_i == '0) || (sym_i == CHAR_PLUS) || (sym_i == CHAR_MINUS);
        for (int j = 0; j < REG_SYMBOLS; j++)
        begin
            if ((BASE_W'(j) > {1'b0, idx_reg}) && (BASE_W'(j) < base_reg)
                && (sym_at(alph, DIGIT_W'(j)) == sym_i))
            begin
                check_bad = 1'b1;
            end
        end
    end

    // Shared divider: one byte of the dividend per cycle, restoring steps.
    always_comb
    begin
        rem_in   = (step_reg == '0) ? '0 : rem_reg;
        rem_calc = rem_in;
        qbyte    = '0;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            rem_calc = {rem_calc[BASE_W-2:0], div_reg[VALUE_BITS-1-k]};
            if (rem_calc >= base_reg)
            begin
                rem_calc = rem_calc - base_reg;
                qbyte[STEP_BITS-1-k] = 1'b1;
            end
        end
        div_shift = {div_reg[VALUE_BITS-STEP_BITS-1:0], qbyte};
    end

    assign out_load = !m_tvalid_reg || m_tready;
    assign rd_ptr   = PTR_W'(cnt_reg - CNT_W'(1));
    assign digit_we = (state_reg == ST_DIVIDE) && (step_reg == STEP_W'(STEPS - 1));

    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        idx_next      = idx_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CHECK;
                    base_next  = radix_reg;
                    idx_next   = '0;
                    neg_next   = s_tdata[VALUE_BITS-1];
                    div_next   = s_tdata[VALUE_BITS-1] ? (~s_tdata + VALUE_BITS'(1))
                                                       : s_tdata;
                    step_next  = '0;
                    cnt_next   = '0;
                end
            end
            ST_CHECK:
            begin
                if (check_bad)
                begin
                    state_next = ST_IDLE;
                end
                else if ({1'b0, idx_reg} == base_reg - BASE_W'(1))
                begin
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    idx_next = idx_reg + DIGIT_W'(1);
                end
            end
            ST_DIVIDE:
            begin
                div_next  = div_shift;
                rem_next  = rem_calc;
                step_next = (step_reg == STEP_W'(STEPS - 1)) ? '0 : step_reg + STEP_W'(1);
                if (digit_we)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if ((div_shift == '0) || (cnt_reg == CNT_W'(MAX_DIGITS - 1)))
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    if (neg_reg)
                    begin
                        neg_next     = 1'b0;
                        m_tdata_next = CHAR_MINUS;
                        m_tlast_next = 1'b0;
                    end
                    else
                    begin
                        m_tdata_next = sym_at(alph, digit_mem[rd_ptr]);
                        m_tlast_next = (cnt_reg == CNT_W'(1));
                        cnt_next     = cnt_reg - CNT_W'(1);
                        if (cnt_reg == CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            base_reg     <= '0;
            idx_reg      <= '0;
            step_reg     <= '0;
            cnt_reg      <= '0;
            neg_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            idx_reg      <= idx_next;
            step_reg     <= step_next;
            cnt_reg      <= cnt_next;
            neg_reg      <= neg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        if (digit_we)
        begin
            digit_mem[cnt_reg[PTR_W-1:0]] <= rem_calc[DIGIT_W-1:0];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Every accepted value starts with the alphabet check.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_CHECK)
        else $error("accepted value did not enter the alphabet check");

    // The partial remainder carried between divider steps stays below the base.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) && (step_reg != '0) |-> rem_reg < base_reg)
        else $error("divider remainder not below the base");

    // Output always has at least one digit to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> cnt_reg != '0)
        else $error("emit phase entered with no digits");

    // The final character of a text is never the minus sign.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && out_load && neg_reg |=> !m_tlast_reg)
        else $error("minus sign flagged as last character");

endmodule

`default_nettype wire
